[rtl/trd_pkg.sv]
package trd_pkg;

    // Input word kinds (s_tuser)
    localparam logic [2:0] FUNC_TICK        = 3'd0;
    localparam logic [2:0] FUNC_STATUS      = 3'd1;
    localparam logic [2:0] FUNC_STATUS_FAIL = 3'd2;
    localparam logic [2:0] FUNC_RECORD      = 3'd3;
    localparam logic [2:0] FUNC_RECORD_FAIL = 3'd4;

    // Result word kinds (m_tuser)
    localparam logic [1:0] KIND_SLOT  = 2'd0;
    localparam logic [1:0] KIND_CLEAR = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    // Register indexes (paddr[3:2])
    localparam logic [1:0] REG_PRESENT = 2'd0;
    localparam logic [1:0] REG_WIDTH   = 2'd1;
    localparam logic [1:0] REG_HEIGHT  = 2'd2;
    localparam logic [1:0] REG_STALE   = 2'd3;

    localparam int SLOT_COUNT_DEF = 5;
    // slot index carried between controller and datapath; covers up to 16 slots
    localparam int IDX_W = 4;

    localparam int          STATUS_READY_BIT = 7;
    localparam logic [7:0]  COUNT_MASK       = 8'h0F;
    localparam int          RECORD_LEN       = 8;
    localparam logic [15:0] AREA_MAX         = 16'd255;
    localparam logic [15:0] MS_MAX           = 16'hFFFF;

    localparam logic        PRESENT_RST = 1'b1;
    localparam logic [15:0] WIDTH_RST   = 16'd1024;
    localparam logic [15:0] HEIGHT_RST  = 16'd600;
    localparam logic [15:0] STALE_RST   = 16'd1000;

    typedef struct packed {
        logic        present;
        logic [15:0] width_px;
        logic [15:0] height_px;
        logic [15:0] stale_ms;
    } cfg_t;

    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
        logic [7:0]  area;
        logic        pressed;
    } slot_rec_t;

    // what one accepted word asks to publish
    typedef struct packed {
        logic       emit_slots;
        logic       use_pending;
        logic       has_tail;
        logic [1:0] tail_kind;
    } plan_t;

    // controller to datapath
    typedef struct packed {
        logic             accept;
        logic             load;
        logic             tail;
        logic [IDX_W-1:0] slot;
        logic             use_pending;
        logic [1:0]       tail_kind;
        logic             last;
    } cmd_t;

endpackage

[rtl/trd_regs.sv]
module trd_regs (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [3:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    output trd_pkg::cfg_t cfg
);

    trd_pkg::cfg_t cfg_reg;
    logic          wr_en;
    logic [1:0]    reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];
    assign cfg     = cfg_reg;

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.present   <= trd_pkg::PRESENT_RST;
            cfg_reg.width_px  <= trd_pkg::WIDTH_RST;
            cfg_reg.height_px <= trd_pkg::HEIGHT_RST;
            cfg_reg.stale_ms  <= trd_pkg::STALE_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                trd_pkg::REG_PRESENT: cfg_reg.present   <= pwdata[0];
                trd_pkg::REG_WIDTH:   cfg_reg.width_px  <= pwdata[15:0];
                trd_pkg::REG_HEIGHT:  cfg_reg.height_px <= pwdata[15:0];
                trd_pkg::REG_STALE:   cfg_reg.stale_ms  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // read back
    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            trd_pkg::REG_PRESENT: prdata = {31'd0, cfg_reg.present};
            trd_pkg::REG_WIDTH:   prdata = {16'd0, cfg_reg.width_px};
            trd_pkg::REG_HEIGHT:  prdata = {16'd0, cfg_reg.height_px};
            trd_pkg::REG_STALE:   prdata = {16'd0, cfg_reg.stale_ms};
            default:              prdata = '0;
        endcase
    end

endmodule

[rtl/trd_datapath.sv]
module trd_datapath #(
    parameter int SLOT_COUNT = trd_pkg::SLOT_COUNT_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  trd_pkg::cfg_t  cfg,
    input  logic [2:0]     func,
    input  logic [7:0]     data_byte,
    input  trd_pkg::cmd_t  cmd,
    output trd_pkg::plan_t plan,
    output logic [1:0]     out_kind,
    output logic [2:0]     out_slot,
    output logic [15:0]    out_x,
    output logic [15:0]    out_y,
    output logic [7:0]     out_area,
    output logic           out_pressed,
    output logic [5:0]     out_len,
    output logic           out_last
);

    localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CNT_W  = $clog2(SLOT_COUNT + 1);
    localparam int REC_BYTES = trd_pkg::RECORD_LEN - 1;

    // decoder state
    logic                phase_reg, phase_next;
    logic [CNT_W-1:0]    expected_reg, expected_next;
    logic [5:0]          byte_idx_reg, byte_idx_next;
    logic [7:0]          record_reg [REC_BYTES];
    logic [7:0]          record_next [REC_BYTES];
    trd_pkg::slot_rec_t  pending_reg [SLOT_COUNT];
    trd_pkg::slot_rec_t  pending_next [SLOT_COUNT];
    logic [15:0]         ms_reg, ms_next;
    logic                seen_reg, seen_next;
    logic [5:0]          read_len_reg, read_len_next;

    // result word register
    logic [1:0]          kind_reg;
    logic [2:0]          slot_reg;
    logic [15:0]         x_reg;
    logic [15:0]         y_reg;
    logic [7:0]          area_reg;
    logic                pressed_reg;
    logic [5:0]          len_reg;
    logic                last_reg;

    // record decode
    logic [2:0]          rec_off;
    logic [2:0]          rec_pos;
    logic [3:0]          track;
    logic [3:0]          rec_idx;
    logic                idx_ok;
    logic [15:0]         raw_x, raw_y, raw_sz;
    trd_pkg::slot_rec_t  new_rec;
    logic                stale;
    logic [3:0]          cnt;

    assign rec_off = byte_idx_reg[2:0];
    assign rec_pos = byte_idx_reg[5:3];
    assign track   = record_reg[0][3:0];
    assign rec_idx = (32'(track) < SLOT_COUNT) ? track : {1'b0, rec_pos};
    assign idx_ok  = 32'(rec_idx) < SLOT_COUNT;
    assign raw_x   = {record_reg[2], record_reg[1]};
    assign raw_y   = {record_reg[4], record_reg[3]};
    assign raw_sz  = {record_reg[6], record_reg[5]};
    assign stale   = seen_reg && (ms_reg >= cfg.stale_ms);
    assign cnt     = data_byte[3:0] & trd_pkg::COUNT_MASK[3:0];

    // clamp and saturate one record
    always_comb begin
        new_rec.x       = (raw_x < cfg.width_px)  ? raw_x : cfg.width_px - 16'd1;
        new_rec.y       = (raw_y < cfg.height_px) ? raw_y : cfg.height_px - 16'd1;
        new_rec.area    = (raw_sz > trd_pkg::AREA_MAX) ? trd_pkg::AREA_MAX[7:0] : raw_sz[7:0];
        new_rec.pressed = 1'b1;
    end

    // event decode
    always_comb begin
        plan          = '0;
        phase_next    = phase_reg;
        expected_next = expected_reg;
        byte_idx_next = byte_idx_reg;
        ms_next       = ms_reg;
        seen_next     = seen_reg;
        read_len_next = read_len_reg;
        for (int i = 0; i < REC_BYTES; i++) record_next[i] = record_reg[i];
        for (int i = 0; i < SLOT_COUNT; i++) pending_next[i] = pending_reg[i];

        case (func) inside
            trd_pkg::FUNC_TICK: begin
                if (ms_reg != trd_pkg::MS_MAX) ms_next = ms_reg + 16'd1;
            end
            trd_pkg::FUNC_STATUS, trd_pkg::FUNC_STATUS_FAIL: begin
                phase_next = 1'b0;
                if (!cfg.present) begin
                    plan.emit_slots = 1'b1;
                end else if (func == trd_pkg::FUNC_STATUS_FAIL
                             || !data_byte[trd_pkg::STATUS_READY_BIT]) begin
                    if (stale) begin
                        plan.emit_slots = 1'b1;
                        ms_next         = '0;
                    end
                end else if (cnt == 4'd0 || 32'(cnt) > SLOT_COUNT) begin
                    plan.emit_slots = 1'b1;
                    plan.has_tail   = 1'b1;
                    plan.tail_kind  = trd_pkg::KIND_CLEAR;
                    ms_next         = '0;
                    seen_next       = 1'b1;
                end else begin
                    phase_next     = 1'b1;
                    expected_next  = cnt[CNT_W-1:0];
                    byte_idx_next  = '0;
                    read_len_next  = {cnt[2:0], 3'b000};
                    for (int i = 0; i < SLOT_COUNT; i++) pending_next[i] = '0;
                    plan.has_tail  = 1'b1;
                    plan.tail_kind = trd_pkg::KIND_READ;
                end
            end
            trd_pkg::FUNC_RECORD: begin
                if (phase_reg) begin
                    if (rec_off != 3'd7) begin
                        for (int i = 0; i < REC_BYTES; i++)
                            if (rec_off == 3'(i)) record_next[i] = data_byte;
                    end else begin
                        for (int i = 0; i < SLOT_COUNT; i++)
                            if (idx_ok && rec_idx == 4'(i)) pending_next[i] = new_rec;
                        if ((32'(rec_pos) + 1) >= 32'(expected_reg)) begin
                            plan.emit_slots  = 1'b1;
                            plan.use_pending = 1'b1;
                            plan.has_tail    = 1'b1;
                            plan.tail_kind   = trd_pkg::KIND_CLEAR;
                            ms_next          = '0;
                            seen_next        = 1'b1;
                            phase_next       = 1'b0;
                        end
                    end
                    byte_idx_next = byte_idx_reg + 6'd1;
                end
            end
            trd_pkg::FUNC_RECORD_FAIL: begin
                if (phase_reg) begin
                    if (stale) begin
                        plan.emit_slots = 1'b1;
                        ms_next         = '0;
                    end
                    plan.has_tail  = 1'b1;
                    plan.tail_kind = trd_pkg::KIND_CLEAR;
                    phase_next     = 1'b0;
                end
            end
            default: ;
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= 1'b0;
            expected_reg <= '0;
            byte_idx_reg <= '0;
            ms_reg       <= '0;
            seen_reg     <= 1'b0;
            for (int i = 0; i < SLOT_COUNT; i++) pending_reg[i] <= '0;
        end else if (cmd.accept) begin
            phase_reg    <= phase_next;
            expected_reg <= expected_next;
            byte_idx_reg <= byte_idx_next;
            ms_reg       <= ms_next;
            seen_reg     <= seen_next;
            for (int i = 0; i < SLOT_COUNT; i++) pending_reg[i] <= pending_next[i];
        end
    end

    // record bytes and read length
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            read_len_reg <= read_len_next;
            for (int i = 0; i < REC_BYTES; i++) record_reg[i] <= record_next[i];
        end
    end

    // result word
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            last_reg <= cmd.last;
            if (cmd.tail) begin
                kind_reg    <= cmd.tail_kind;
                slot_reg    <= '0;
                x_reg       <= '0;
                y_reg       <= '0;
                area_reg    <= '0;
                pressed_reg <= 1'b0;
                len_reg     <= (cmd.tail_kind == trd_pkg::KIND_READ) ? read_len_reg : 6'd0;
            end else begin
                kind_reg <= trd_pkg::KIND_SLOT;
                slot_reg <= cmd.slot[2:0];
                len_reg  <= '0;
                if (cmd.use_pending) begin
                    x_reg       <= pending_reg[cmd.slot[SLOT_W-1:0]].x;
                    y_reg       <= pending_reg[cmd.slot[SLOT_W-1:0]].y;
                    area_reg    <= pending_reg[cmd.slot[SLOT_W-1:0]].area;
                    pressed_reg <= pending_reg[cmd.slot[SLOT_W-1:0]].pressed;
                end else begin
                    x_reg       <= '0;
                    y_reg       <= '0;
                    area_reg    <= '0;
                    pressed_reg <= 1'b0;
                end
            end
        end
    end

    assign out_kind    = kind_reg;
    assign out_slot    = slot_reg;
    assign out_x       = x_reg;
    assign out_y       = y_reg;
    assign out_area    = area_reg;
    assign out_pressed = pressed_reg;
    assign out_len     = len_reg;
    assign out_last    = last_reg;

endmodule

[rtl/trd_ctrl.sv]
module trd_ctrl #(
    parameter int SLOT_COUNT = trd_pkg::SLOT_COUNT_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    output logic           m_tvalid,
    input  logic           m_tready,
    input  trd_pkg::plan_t plan,
    output trd_pkg::cmd_t  cmd
);

    localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int IDX_W  = trd_pkg::IDX_W;
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOT_COUNT - 1);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SLOTS = 3'b010,
        ST_TAIL  = 3'b100
    } state_t;

    state_t            state_reg, state_next;
    logic [SLOT_W-1:0] slot_cnt_reg, slot_cnt_next;
    logic              use_pending_reg, use_pending_next;
    logic              has_tail_reg, has_tail_next;
    logic [1:0]        tail_kind_reg, tail_kind_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic              accept;
    logic              out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;

    // sequencer
    always_comb begin
        state_next       = state_reg;
        slot_cnt_next    = slot_cnt_reg;
        use_pending_next = use_pending_reg;
        has_tail_next    = has_tail_reg;
        tail_kind_next   = tail_kind_reg;
        cmd              = '0;
        cmd.accept       = accept;
        cmd.slot         = IDX_W'(slot_cnt_reg);
        cmd.use_pending  = use_pending_reg;
        cmd.tail_kind    = tail_kind_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    use_pending_next = plan.use_pending;
                    has_tail_next    = plan.has_tail;
                    tail_kind_next   = plan.tail_kind;
                    slot_cnt_next    = '0;
                    if (plan.emit_slots)    state_next = ST_SLOTS;
                    else if (plan.has_tail) state_next = ST_TAIL;
                end
            end
            ST_SLOTS: begin
                if (out_free) begin
                    cmd.load = 1'b1;
                    cmd.last = (slot_cnt_reg == SLOT_LAST) && !has_tail_reg;
                    if (slot_cnt_reg == SLOT_LAST) begin
                        state_next = has_tail_reg ? ST_TAIL : ST_IDLE;
                    end else begin
                        slot_cnt_next = slot_cnt_reg + SLOT_W'(1);
                    end
                end
            end
            ST_TAIL: begin
                if (out_free) begin
                    cmd.load   = 1'b1;
                    cmd.tail   = 1'b1;
                    cmd.last   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        if (cmd.load)      m_tvalid_next = 1'b1;
        else if (m_tready) m_tvalid_next = 1'b0;
        else               m_tvalid_next = m_tvalid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        slot_cnt_reg    <= slot_cnt_next;
        use_pending_reg <= use_pending_next;
        has_tail_reg    <= has_tail_next;
        tail_kind_reg   <= tail_kind_next;
    end

`ifndef SYNTHESIS
    // a new word is never loaded over one still waiting
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |-> (!m_tvalid_reg || m_tready))
        else $error("result loaded over a pending word");

    // the final word of a sequence returns the sequencer to idle
    a_last_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.load && cmd.last) |=> (state_reg == ST_IDLE))
        else $error("sequencer busy after last word");

    // a word with nothing to publish leaves the sequencer idle
    a_quiet_word: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !plan.emit_slots && !plan.has_tail) |=> (state_reg == ST_IDLE))
        else $error("quiet word started a sequence");

    // the slot counter stays within the slot range
    a_slot_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SLOTS) |-> (32'(slot_cnt_reg) < SLOT_COUNT))
        else $error("slot counter out of range");
`endif

endmodule

[rtl/touch_report_decoder.sv]
// An accepted input word with results to publish moves the sequencer out of idle,
// which loads them into the output register. One input word at a time; a word that
// publishes N results (0 to 6) holds the input until its last result is loaded, set
// by the result sequencer that loads one word per cycle while the output is free.
// Reset: synchronous, active low; config registers to defaults, all slots released.
module touch_report_decoder #(
    parameter int SLOT_COUNT = trd_pkg::SLOT_COUNT_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input words
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic [2:0]  s_tuser,   // [2:0] func
    // result words
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [2:0] slot, [18:3] pos_x, [34:19] pos_y,
                                   // [42:35] contact_area, [43] pressed,
                                   // [49:44] read_length, [55:50] zero
    output logic [1:0]  m_tuser,   // [1:0] kind
    output logic        m_tlast    // last result of an input word
);

    trd_pkg::cfg_t  cfg;
    trd_pkg::plan_t plan;
    trd_pkg::cmd_t  cmd;
    logic [2:0]     out_slot;
    logic [15:0]    out_x;
    logic [15:0]    out_y;
    logic [7:0]     out_area;
    logic           out_pressed;
    logic [5:0]     out_len;

    // configuration registers
    trd_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // handshake and result sequencing
    trd_ctrl #(.SLOT_COUNT(SLOT_COUNT)) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .plan     (plan),
        .cmd      (cmd)
    );

    // report decode and slot store
    trd_datapath #(.SLOT_COUNT(SLOT_COUNT)) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .func        (s_tuser),
        .data_byte   (s_tdata),
        .cmd         (cmd),
        .plan        (plan),
        .out_kind    (m_tuser),
        .out_slot    (out_slot),
        .out_x       (out_x),
        .out_y       (out_y),
        .out_area    (out_area),
        .out_pressed (out_pressed),
        .out_len     (out_len),
        .out_last    (m_tlast)
    );

    assign m_tdata = {6'd0, out_len, out_pressed, out_area, out_y, out_x, out_slot};

endmodule
